/* hw/rtl/srsa_pkg.sv */
package srsa_pkg;

	localparam logic [2:0] CMD_INIT    = 3'd0;
	localparam logic [2:0] CMD_ALLOC   = 3'd1;
	localparam logic [2:0] CMD_FREE    = 3'd2;
	localparam logic [2:0] CMD_RESTORE = 3'd3;
	localparam logic [2:0] CMD_SPILL   = 3'd4;
	localparam logic [2:0] CMD_CHECK   = 3'd5;

	localparam logic [2:0] KIND_DONE  = 3'd0;
	localparam logic [2:0] KIND_PUSH  = 3'd1;
	localparam logic [2:0] KIND_POP   = 3'd2;
	localparam logic [2:0] KIND_GRANT = 3'd3;
	localparam logic [2:0] KIND_ERROR = 3'd4;

	localparam logic [3:0] ERR_NONE        = 4'd0;
	localparam logic [3:0] ERR_RESPILL     = 4'd1;
	localparam logic [3:0] ERR_OVERFLOW    = 4'd2;
	localparam logic [3:0] ERR_EMPTY       = 4'd3;
	localparam logic [3:0] ERR_TOP         = 4'd4;
	localparam logic [3:0] ERR_POP_OWNED   = 4'd5;
	localparam logic [3:0] ERR_CHK_OWNED   = 4'd6;
	localparam logic [3:0] ERR_CHK_ROT     = 4'd7;
	localparam logic [3:0] ERR_CHK_STACK   = 4'd8;
	localparam logic [3:0] ERR_CHK_ALLOC   = 4'd9;
	localparam logic [3:0] ERR_FULL        = 4'd10;
	localparam logic [3:0] ERR_OWNER       = 4'd11;
	localparam logic [3:0] ERR_FREE_NONE   = 4'd12;
	localparam logic [3:0] ERR_NOT_RECENT  = 4'd13;
	localparam logic [3:0] ERR_FREE_SPILLD = 4'd14;

	localparam int ALLOC_SLOTS = 32;

	// one result beat
	typedef struct packed {
		logic       last;
		logic [3:0] error_code;
		logic [4:0] number_out;
		logic [3:0] reg_out;
		logic [2:0] kind;
	} result_t;

endpackage

/* hw/rtl/srsa_out_buf.sv */
module srsa_out_buf (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  srsa_pkg::result_t in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output srsa_pkg::result_t out_data
);

	logic full_q;
	srsa_pkg::result_t data_q;

	assign in_ready  = !full_q || out_ready;
	assign out_valid = full_q;
	assign out_data  = data_q;

	// single output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q <= 1'b0;
		end else if (in_ready) begin
			full_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_q <= in_data;
		end
	end

endmodule

/* hw/rtl/srsa_core.sv */
module srsa_core #(
	parameter int SCRATCH_REGS = 4,
	parameter int STACK_DEPTH  = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	output logic              cmd_ready,
	input  logic [2:0]        cmd,
	input  logic [3:0]        reg_num,
	input  logic [4:0]        alloc_num,
	output logic              res_valid,
	input  logic              res_ready,
	output srsa_pkg::result_t res,
	output logic              busy
);

	localparam int RW = (SCRATCH_REGS > 1) ? $clog2(SCRATCH_REGS) : 1;
	localparam int SW = $clog2(STACK_DEPTH + 1);
	localparam int SD = STACK_DEPTH + 1;
	localparam int ALLOC_SLOTS_L = srsa_pkg::ALLOC_SLOTS;

	localparam logic [3:0] ST_IDLE    = 4'd0;
	localparam logic [3:0] ST_ALLOC   = 4'd1;
	localparam logic [3:0] ST_FREE    = 4'd2;
	localparam logic [3:0] ST_REST    = 4'd3;
	localparam logic [3:0] ST_REST2   = 4'd4;
	localparam logic [3:0] ST_SPRD    = 4'd5;
	localparam logic [3:0] ST_SPCHK   = 4'd6;
	localparam logic [3:0] ST_SPPUSH  = 4'd7;
	localparam logic [3:0] ST_EMIT    = 4'd8;
	localparam logic [3:0] ST_APUSH   = 4'd9;
	localparam logic [3:0] ST_AGRANT  = 4'd10;
	localparam logic [3:0] ST_CHECK   = 4'd11;

	// register owner file (small, fixed-place reads)
	logic [SCRATCH_REGS-1:0] own_v_q;
	logic [4:0] own_n_q [SCRATCH_REGS];
	logic [RW-1:0] next_q;
	logic [SW-1:0] sp_q;
	logic [5:0] ac_q;
	logic [3:0] err_q;

	// allocation and stack memories
	logic [3:0] areg_mem [ALLOC_SLOTS_L];
	logic       aspl_mem [ALLOC_SLOTS_L];
	logic [4:0] sown_mem [SD];

	logic [3:0] st_q;
	logic [2:0] cmd_q;
	logic [3:0] reg_q;
	logic [4:0] num_q;
	logic [RW-1:0] r_q;
	logic [5:0] k_q;
	logic any_q;
	logic [3:0] kr_q;
	srsa_pkg::result_t pend_q;

	// memory ports
	logic       a_we, s_we, sp_we;
	logic [4:0] a_wa, a_ra;
	logic [3:0] a_wreg;
	logic       sp_wd;
	logic [4:0] sp_wa;
	logic [SW-1:0] s_wa, s_ra;
	logic [4:0] s_wd;
	logic [3:0] areg_rd_q;
	logic       aspl_rd_q;
	logic [4:0] sown_rd_q;

	always_ff @(posedge clk) begin
		if (a_we) areg_mem[a_wa] <= a_wreg;
		if (sp_we) aspl_mem[sp_wa] <= sp_wd;
		if (s_we) sown_mem[s_wa] <= s_wd;
		areg_rd_q <= areg_mem[a_ra];
		aspl_rd_q <= aspl_mem[a_ra];
		sown_rd_q <= sown_mem[s_ra];
	end

	logic emit_ok;
	assign emit_ok  = !res_valid || res_ready;
	assign cmd_ready = (st_q == ST_IDLE) && emit_ok;
	assign busy = (st_q != ST_IDLE) || res_valid;

	function automatic srsa_pkg::result_t mk(logic [2:0] k, logic [3:0] r, logic [4:0] n,
			logic [3:0] e, logic l);
		srsa_pkg::result_t t;
		t.kind = k; t.reg_out = r; t.number_out = n; t.error_code = e; t.last = l;
		return t;
	endfunction

	logic [4:0] own_r;
	logic own_rv;
	logic [4:0] own_f;
	logic own_fv;
	assign own_r  = own_n_q[r_q];
	assign own_rv = own_v_q[r_q];
	assign own_f  = own_n_q[reg_q[RW-1:0]];
	assign own_fv = own_v_q[reg_q[RW-1:0]];

	logic out_v;
	srsa_pkg::result_t out_d;

	// sequencer: read, then modify and write back
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			own_v_q <= '0;
			next_q <= '0;
			sp_q <= '0;
			ac_q <= '0;
			err_q <= srsa_pkg::ERR_NONE;
			res_valid <= 1'b0;
			k_q <= '0;
			any_q <= 1'b0;
		end else begin
			res_valid <= out_v || (res_valid && !res_ready);
			case (st_q)
			ST_IDLE: begin
				if (cmd_valid && cmd_ready) begin
					if (cmd == srsa_pkg::CMD_INIT) begin
						own_v_q <= '0; next_q <= '0; sp_q <= '0; ac_q <= '0;
						err_q <= srsa_pkg::ERR_NONE;
					end else if (err_q != srsa_pkg::ERR_NONE) begin
						st_q <= ST_IDLE;
					end else begin
						case (cmd)
						srsa_pkg::CMD_ALLOC:   st_q <= ST_ALLOC;
						srsa_pkg::CMD_FREE:    st_q <= ({1'b0, reg_num} < 5'(SCRATCH_REGS)) ?
							ST_FREE : ST_IDLE;
						srsa_pkg::CMD_RESTORE: st_q <= ({1'b0, reg_num} < 5'(SCRATCH_REGS)) ?
							ST_REST : ST_IDLE;
						srsa_pkg::CMD_SPILL: begin
							st_q <= ST_SPRD; k_q <= '0; any_q <= 1'b0;
						end
						srsa_pkg::CMD_CHECK:   st_q <= ST_CHECK;
						default:               st_q <= ST_IDLE;
						endcase
					end
				end
			end
			ST_ALLOC: begin
				if (own_rv) st_q <= ST_APUSH;
				else st_q <= ST_AGRANT;
			end
			ST_APUSH: begin
				if (emit_ok) begin
					if (sp_q > SW'(STACK_DEPTH)) begin
						err_q <= srsa_pkg::ERR_OVERFLOW; st_q <= ST_EMIT;
					end else if (aspl_rd_q) begin
						err_q <= srsa_pkg::ERR_RESPILL; st_q <= ST_EMIT;
					end else begin
						sp_q <= sp_q + 1'b1;
						if (sp_q + 1'b1 > SW'(STACK_DEPTH)) begin
							err_q <= srsa_pkg::ERR_OVERFLOW; st_q <= ST_EMIT;
						end else st_q <= ST_AGRANT;
					end
				end
			end
			ST_AGRANT: begin
				if (ac_q >= 6'(ALLOC_SLOTS_L)) err_q <= srsa_pkg::ERR_FULL;
				else begin
					own_v_q[r_q] <= 1'b1;
					own_n_q[r_q] <= ac_q[4:0];
					next_q <= (r_q == RW'(SCRATCH_REGS - 1)) ? '0 : r_q + 1'b1;
					ac_q <= ac_q + 1'b1;
					if (ac_q + 1'b1 >= 6'(STACK_DEPTH)) err_q <= srsa_pkg::ERR_FULL;
				end
				st_q <= ST_EMIT;
			end
			ST_FREE: begin
				own_v_q[reg_q[RW-1:0]] <= 1'b0;
				next_q <= (next_q == '0) ? RW'(SCRATCH_REGS - 1) : next_q - 1'b1;
				if (!own_fv || own_f != num_q) err_q <= srsa_pkg::ERR_OWNER;
				else if (ac_q == '0) err_q <= srsa_pkg::ERR_FREE_NONE;
				else begin
					ac_q <= ac_q - 1'b1;
					if (ac_q - 1'b1 != {1'b0, num_q}) err_q <= srsa_pkg::ERR_NOT_RECENT;
					else if (aspl_rd_q) err_q <= srsa_pkg::ERR_FREE_SPILLD;
				end
				st_q <= ST_EMIT;
			end
			ST_REST: begin
				if (!aspl_rd_q) st_q <= ST_EMIT;
				else if (sp_q == '0) begin
					err_q <= srsa_pkg::ERR_EMPTY; st_q <= ST_EMIT;
				end else begin
					sp_q <= sp_q - 1'b1; st_q <= ST_REST2;
				end
			end
			ST_REST2: begin
				if (sown_rd_q != num_q) err_q <= srsa_pkg::ERR_TOP;
				else if (own_fv) err_q <= srsa_pkg::ERR_POP_OWNED;
				else begin
					own_v_q[reg_q[RW-1:0]] <= 1'b1;
					own_n_q[reg_q[RW-1:0]] <= num_q;
				end
				st_q <= ST_EMIT;
			end
			ST_SPRD: begin
				if (k_q >= ac_q || k_q >= 6'(ALLOC_SLOTS_L)) st_q <= ST_EMIT;
				else st_q <= ST_SPCHK;
			end
			ST_SPCHK: begin
				kr_q <= areg_rd_q;
				if (aspl_rd_q) begin
					k_q <= k_q + 1'b1; st_q <= ST_SPRD;
				end else st_q <= ST_SPPUSH;
			end
			ST_SPPUSH: begin
				if (emit_ok) begin
					any_q <= 1'b1;
					if (sp_q > SW'(STACK_DEPTH)) begin
						err_q <= srsa_pkg::ERR_OVERFLOW; st_q <= ST_EMIT;
					end else begin
						sp_q <= sp_q + 1'b1;
						if (sp_q + 1'b1 > SW'(STACK_DEPTH)) begin
							err_q <= srsa_pkg::ERR_OVERFLOW; st_q <= ST_EMIT;
						end else begin
							if ({1'b0, kr_q} < 5'(SCRATCH_REGS)) own_v_q[kr_q[RW-1:0]] <= 1'b0;
							k_q <= k_q + 1'b1; st_q <= ST_SPRD;
						end
					end
				end
			end
			ST_CHECK: begin
				if (own_v_q != '0) err_q <= srsa_pkg::ERR_CHK_OWNED;
				else if (next_q != '0) err_q <= srsa_pkg::ERR_CHK_ROT;
				else if (sp_q != '0) err_q <= srsa_pkg::ERR_CHK_STACK;
				else if (ac_q != '0) err_q <= srsa_pkg::ERR_CHK_ALLOC;
				st_q <= ST_EMIT;
			end
			ST_EMIT: begin
				// a held push goes out first, then the error beat if any
				if (emit_ok) begin
					if (cmd_q == srsa_pkg::CMD_SPILL && any_q) begin
						any_q <= 1'b0;
						if (err_q == srsa_pkg::ERR_NONE) st_q <= ST_IDLE;
					end else st_q <= ST_IDLE;
				end
			end
			default: st_q <= ST_IDLE;
			endcase
		end
	end

	// operand capture and final beat selection
	always_ff @(posedge clk) begin
		if (cmd_valid && cmd_ready) begin
			cmd_q <= cmd; reg_q <= reg_num; num_q <= alloc_num;
			r_q <= next_q;
		end
		if (st_q == ST_AGRANT)
			pend_q <= mk(srsa_pkg::KIND_GRANT, 4'(r_q), ac_q[4:0], srsa_pkg::ERR_NONE, 1'b1);
		else if (st_q == ST_REST2)
			pend_q <= mk(srsa_pkg::KIND_POP, reg_q, num_q, srsa_pkg::ERR_NONE, 1'b1);
		else if (st_q == ST_SPPUSH) begin
			// spill push is held in pend_q so the final one can carry last
			if (emit_ok)
				pend_q <= mk(srsa_pkg::KIND_PUSH, kr_q, k_q[4:0], srsa_pkg::ERR_NONE, 1'b0);
		end else if (st_q != ST_EMIT && st_q != ST_SPRD && st_q != ST_SPCHK)
			pend_q <= mk(srsa_pkg::KIND_DONE, 4'd0, 5'd0, srsa_pkg::ERR_NONE, 1'b1);
	end

	// memory port control
	always_comb begin
		a_we = 1'b0; a_wa = ac_q[4:0]; a_wreg = 4'(r_q);
		sp_we = 1'b0; sp_wa = ac_q[4:0]; sp_wd = 1'b0;
		s_we = 1'b0; s_wa = sp_q; s_wd = own_r;
		a_ra = num_q; s_ra = sp_q - 1'b1;
		case (st_q)
		ST_IDLE:  a_ra = alloc_num;
		ST_ALLOC: a_ra = own_r;
		ST_SPRD, ST_SPCHK: a_ra = k_q[4:0];
		default: ;
		endcase
		if (st_q == ST_IDLE && cmd_valid && cmd_ready && cmd == srsa_pkg::CMD_ALLOC)
			a_ra = alloc_num;
		if (st_q == ST_APUSH && emit_ok && sp_q <= SW'(STACK_DEPTH)) begin
			s_we = 1'b1; s_wd = own_r;
			if (!aspl_rd_q) begin
				sp_we = 1'b1; sp_wa = own_r; sp_wd = 1'b1;
			end
		end
		if (st_q == ST_AGRANT && ac_q < 6'(ALLOC_SLOTS_L)) begin
			a_we = 1'b1; sp_we = 1'b1; sp_wa = ac_q[4:0]; sp_wd = 1'b0;
		end
		if (st_q == ST_REST2 && sown_rd_q == num_q && !own_fv) begin
			sp_we = 1'b1; sp_wa = num_q; sp_wd = 1'b0;
		end
		if (st_q == ST_SPPUSH && emit_ok && sp_q <= SW'(STACK_DEPTH)) begin
			s_we = 1'b1; s_wd = k_q[4:0];
			sp_we = 1'b1; sp_wa = k_q[4:0]; sp_wd = 1'b1;
		end
	end

	// result beat
	always_comb begin
		out_v = 1'b0;
		out_d = pend_q;
		if (st_q == ST_IDLE && cmd_valid && cmd_ready) begin
			if (cmd == srsa_pkg::CMD_INIT) begin
				out_v = 1'b1;
				out_d = mk(srsa_pkg::KIND_DONE, 4'd0, 5'd0, srsa_pkg::ERR_NONE, 1'b1);
			end else if (err_q != srsa_pkg::ERR_NONE) begin
				out_v = 1'b1;
				out_d = mk(srsa_pkg::KIND_ERROR, 4'd0, 5'd0, err_q, 1'b1);
			end else if (cmd == srsa_pkg::CMD_FREE || cmd == srsa_pkg::CMD_RESTORE) begin
				out_v = !({1'b0, reg_num} < 5'(SCRATCH_REGS));
				out_d = mk(srsa_pkg::KIND_DONE, 4'd0, 5'd0, srsa_pkg::ERR_NONE, 1'b1);
			end else if (!(cmd == srsa_pkg::CMD_ALLOC || cmd == srsa_pkg::CMD_SPILL ||
					cmd == srsa_pkg::CMD_CHECK)) begin
				out_v = 1'b1;
				out_d = mk(srsa_pkg::KIND_DONE, 4'd0, 5'd0, srsa_pkg::ERR_NONE, 1'b1);
			end
		end else if (st_q == ST_APUSH && emit_ok) begin
			out_v = 1'b1;
			out_d = mk(srsa_pkg::KIND_PUSH, 4'(r_q), own_r, srsa_pkg::ERR_NONE, 1'b0);
		end else if (st_q == ST_SPPUSH && emit_ok) begin
			// release the previous held push
			out_v = any_q;
			out_d = pend_q;
		end else if (st_q == ST_EMIT && emit_ok) begin
			if (cmd_q == srsa_pkg::CMD_SPILL && any_q) begin
				out_v = 1'b1;
				out_d = pend_q;
				out_d.last = (err_q == srsa_pkg::ERR_NONE);
			end else if (err_q != srsa_pkg::ERR_NONE) begin
				out_v = 1'b1;
				out_d = mk(srsa_pkg::KIND_ERROR, 4'd0, 5'd0, err_q, 1'b1);
			end else if (cmd_q == srsa_pkg::CMD_SPILL) begin
				out_v = 1'b1;
				out_d = mk(srsa_pkg::KIND_DONE, 4'd0, 5'd0, srsa_pkg::ERR_NONE, 1'b1);
			end else begin
				out_v = 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_v) res <= out_d;
	end

endmodule

/* hw/rtl/scratch_register_spill_allocator.sv */
// Scratch register allocator with a spill stack. One command beat at a time:
// init, unknown codes, ignored operands and commands refused by a sticky error
// finish straight from idle; free and check run through the sequencer, as do
// allocate, which first pushes the register's owner when it is owned, and
// restore, which pops when the number is spilled. Spill-all walks the allocation
// table through its registered memory read port, pushes each unspilled entry and
// stops on an error. Results leave through the core's result register and one
// output register; a stalled result stalls the sequencer. An error is sticky until init.
module scratch_register_spill_allocator #(
	parameter int SCRATCH_REGS = 4,
	parameter int STACK_DEPTH  = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // cmd[2:0], reg_num[6:3], alloc_num[11:7]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // kind[2:0], reg_out[6:3], number_out[11:7], error_code[15:12]
	output logic        m_tlast
);

	srsa_pkg::result_t core_res, buf_res;
	logic core_valid, core_ready, busy;

	srsa_core #(.SCRATCH_REGS(SCRATCH_REGS), .STACK_DEPTH(STACK_DEPTH)) u_core (
		.clk(clk), .arst_n(arst_n),
		.cmd_valid(s_tvalid), .cmd_ready(s_tready),
		.cmd(s_tdata[2:0]), .reg_num(s_tdata[6:3]), .alloc_num(s_tdata[11:7]),
		.res_valid(core_valid), .res_ready(core_ready), .res(core_res), .busy(busy)
	);

	srsa_out_buf u_buf (
		.clk(clk), .arst_n(arst_n),
		.in_valid(core_valid), .in_ready(core_ready), .in_data(core_res),
		.out_valid(m_tvalid), .out_ready(m_tready), .out_data(buf_res)
	);

	assign m_tdata = {buf_res.error_code, buf_res.number_out, buf_res.reg_out, buf_res.kind};
	assign m_tlast = buf_res.last;

`ifndef SYNTH
	// no new command while a result is still owed
	a_busy_block: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> (!busy || core_ready))
		else $error("command taken while result pending");
	// an error beat always closes the command
	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[2:0] == srsa_pkg::KIND_ERROR) |-> m_tlast)
		else $error("error beat without last");
	// an error beat carries a code
	a_err_code: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[2:0] == srsa_pkg::KIND_ERROR) |-> m_tdata[15:12] != 4'd0)
		else $error("error beat without code");
`endif

endmodule
